FILE: rtl/core/lbg_pkg.sv
// Shared types, constants and the discharge curve of the battery gauge.
`default_nettype none

package lbg_pkg;

  // Field widths of the converter sample and the results.
  localparam int ADC_BITS = 12;
  localparam int MV_W     = 16;
  localparam int PCT_W    = 7;
  localparam int CNT_W    = 8;
  localparam int SUM_W    = ADC_BITS + CNT_W;
  localparam int EMA_W    = 32;
  localparam int REG_W    = 16;
  localparam int REG_IDX_W = 2;

  // Conversion constants.
  localparam logic [ADC_BITS-1:0] ADC_FULL    = ADC_BITS'((1 << ADC_BITS) - 1);
  localparam logic [11:0]         PIN_FULL_MV = 12'd3300;
  localparam logic [EMA_W:0]      ROUND_HALF  = 33'h0_0000_8000;
  localparam logic [PCT_W-1:0]    PCT_FULL    = 7'd100;
  localparam logic [MV_W-1:0]     MV_MAX      = 16'hFFFF;

  // Shared divider sizes.
  localparam int DIV_NUM_W = 24;
  localparam int DIV_DEN_W = 16;
  localparam int DIV_STEPS = DIV_NUM_W;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS);

  // Configuration register indexes.
  localparam logic [REG_IDX_W-1:0] REG_OVERSAMPLE = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_DIV_GAIN   = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_CAL_TRIM   = 2'd2;
  localparam logic [REG_IDX_W-1:0] REG_EMA_ALPHA  = 2'd3;

  // Reset values of the configuration registers.
  localparam logic [CNT_W-1:0] OVERSAMPLE_RST = 8'd16;
  localparam logic [REG_W-1:0] DIV_GAIN_RST   = 16'd16384;
  localparam logic [REG_W-1:0] CAL_TRIM_RST   = 16'd32768;
  localparam logic [REG_W-1:0] EMA_ALPHA_RST  = 16'd6554;

  // Li-Po discharge curve, from full charge down to empty.
  localparam int CURVE_POINTS = 21;
  localparam int CURVE_IDX_W  = $clog2(CURVE_POINTS);
  localparam logic [MV_W-1:0] CURVE_MV [CURVE_POINTS] = '{
    16'd4200, 16'd4150, 16'd4110, 16'd4080, 16'd4020, 16'd3980, 16'd3950,
    16'd3910, 16'd3870, 16'd3850, 16'd3840, 16'd3820, 16'd3800, 16'd3790,
    16'd3770, 16'd3750, 16'd3730, 16'd3710, 16'd3690, 16'd3610, 16'd3270
  };
  localparam logic [PCT_W-1:0] CURVE_PCT [CURVE_POINTS] = '{
    7'd100, 7'd95, 7'd90, 7'd85, 7'd80, 7'd75, 7'd70,
    7'd65,  7'd60, 7'd55, 7'd50, 7'd45, 7'd40, 7'd35,
    7'd30,  7'd25, 7'd20, 7'd15, 7'd10, 7'd5,  7'd0
  };

  // Input and result items.
  typedef struct packed {
    logic [ADC_BITS-1:0] raw_sample;
    logic                sample_valid;
    logic                seed;
  } lbg_in_t;

  typedef struct packed {
    logic [MV_W-1:0]  battery_mv;
    logic [PCT_W-1:0] battery_percent;
  } lbg_out_t;

  // Configuration seen by the datapath.
  typedef struct packed {
    logic [CNT_W-1:0] oversample_count;
    logic [REG_W-1:0] divider_gain;
    logic [REG_W-1:0] cal_trim;
    logic [REG_W-1:0] ema_alpha;
  } lbg_cfg_t;

  // One finished group handed from the front to the back.
  typedef struct packed {
    logic [SUM_W-1:0] sum;
    logic [CNT_W-1:0] good;
    logic             seed;
  } lbg_job_t;

  // Shared divider request and response.
  typedef struct packed {
    logic                 start;
    logic [DIV_NUM_W-1:0] dividend;
    logic [DIV_DEN_W-1:0] divisor;
  } lbg_div_req_t;

  typedef struct packed {
    logic                 done;
    logic [DIV_NUM_W-1:0] quotient;
  } lbg_div_rsp_t;

  // Back-end sequencer states.
  typedef enum logic [4:0] {
    ST_IDLE,
    ST_AVG_GO,
    ST_AVG_WAIT,
    ST_MUL_PIN,
    ST_PIN_DIV,
    ST_MUL_GAIN,
    ST_MUL_TRIM,
    ST_EMA_DIFF,
    ST_EMA_MUL,
    ST_EMA_UPD,
    ST_ROUND,
    ST_SCAN,
    ST_SEG_MUL,
    ST_SOC_GO,
    ST_SOC_WAIT,
    ST_EMIT
  } lbg_state_t;

endpackage

`default_nettype wire

FILE: rtl/core/lbg_front.sv
// Front end: accumulates samples into groups and queues each finished group.
`default_nettype none

module lbg_front (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        in_valid,
  output      logic                        in_ready,
  input  wire lbg_pkg::lbg_in_t            in_item,
  input  wire logic [lbg_pkg::CNT_W-1:0]   oversample_count,
  input  wire logic                        q_full,
  output      logic                        q_push,
  output      lbg_pkg::lbg_job_t           q_data
);

  logic [lbg_pkg::SUM_W-1:0] sample_sum;
  logic [lbg_pkg::CNT_W-1:0] good_count;
  logic [lbg_pkg::CNT_W-1:0] group_count;

  logic [lbg_pkg::SUM_W-1:0] sample_sum_next;
  logic [lbg_pkg::CNT_W-1:0] good_count_next;
  logic [lbg_pkg::CNT_W:0]   group_count_next;
  logic [lbg_pkg::CNT_W:0]   group_size;
  logic                      accept;
  logic                      group_end;

  // Samples are taken whenever the queue has room for a finished group.
  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;

  // A group size of zero behaves as one.
  assign group_size = (oversample_count == '0) ? (lbg_pkg::CNT_W+1)'(1)
                                               : {1'b0, oversample_count};

  // Running sums including the item being accepted.
  always_comb begin
    sample_sum_next  = sample_sum;
    good_count_next  = good_count;
    if (in_item.sample_valid) begin
      sample_sum_next = sample_sum + lbg_pkg::SUM_W'(in_item.raw_sample);
      good_count_next = good_count + 1'b1;
    end
    group_count_next = {1'b0, group_count} + 1'b1;
  end

  assign group_end = group_count_next >= group_size;

  // Hand the finished group to the back end.
  assign q_push      = accept && group_end;
  assign q_data.sum  = sample_sum_next;
  assign q_data.good = good_count_next;
  assign q_data.seed = in_item.seed;

  // Group accumulators.
  always_ff @(posedge clk) begin
    if (rst) begin
      sample_sum  <= '0;
      good_count  <= '0;
      group_count <= '0;
    end else if (accept) begin
      if (group_end) begin
        sample_sum  <= '0;
        good_count  <= '0;
        group_count <= '0;
      end else begin
        sample_sum  <= sample_sum_next;
        good_count  <= good_count_next;
        group_count <= group_count_next[lbg_pkg::CNT_W-1:0];
      end
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/lbg_queue.sv
// Short first-in first-out queue of finished groups between front and back.
`default_nettype none

module lbg_queue #(
  parameter int DEPTH = 2
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              push,
  input  wire lbg_pkg::lbg_job_t push_data,
  input  wire logic              pop,
  output      lbg_pkg::lbg_job_t pop_data,
  output      logic              full,
  output      logic              empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  lbg_pkg::lbg_job_t entries [DEPTH];
  logic [PTR_W-1:0]  wr_ptr;
  logic [PTR_W-1:0]  rd_ptr;
  logic [CNT_W-1:0]  count;

  assign full     = count == CNT_W'(DEPTH);
  assign empty    = count == '0;
  assign pop_data = entries[rd_ptr];

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push && !full) begin
      entries[wr_ptr] <= push_data;
    end
  end

  // Pointers and fill level.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push && !full) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop && !empty) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if ((push && !full) && !(pop && !empty)) begin
        count <= count + 1'b1;
      end else if (!(push && !full) && (pop && !empty)) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/lbg_divider.sv
// Shared restoring divider that yields one quotient bit per cycle.
`default_nettype none

module lbg_divider (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire lbg_pkg::lbg_div_req_t req,
  output      lbg_pkg::lbg_div_rsp_t rsp
);

  logic                                busy;
  logic                                done;
  logic [lbg_pkg::DIV_CNT_W-1:0]       step;
  logic [lbg_pkg::DIV_DEN_W-1:0]       divisor;
  logic [lbg_pkg::DIV_DEN_W-1:0]       rem;
  logic [lbg_pkg::DIV_NUM_W-1:0]       quo;
  logic [lbg_pkg::DIV_DEN_W:0]         trial;
  logic [lbg_pkg::DIV_DEN_W:0]         trial_sub;
  logic                                fits;

  // One restoring step: shift in the next dividend bit and try to subtract.
  assign trial     = {rem, quo[lbg_pkg::DIV_NUM_W-1]};
  assign trial_sub = trial - {1'b0, divisor};
  assign fits      = trial >= {1'b0, divisor};

  assign rsp.done     = done;
  assign rsp.quotient = quo;

  // Control: the step counter runs while busy and marks completion.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        step <= '0;
      end else if (busy) begin
        step <= step + 1'b1;
        if (step == lbg_pkg::DIV_CNT_W'(lbg_pkg::DIV_STEPS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Datapath: the quotient register starts as the dividend and fills with result bits.
  always_ff @(posedge clk) begin
    if (req.start) begin
      divisor <= req.divisor;
      rem     <= '0;
      quo     <= req.dividend;
    end else if (busy) begin
      rem <= fits ? trial_sub[lbg_pkg::DIV_DEN_W-1:0] : trial[lbg_pkg::DIV_DEN_W-1:0];
      quo <= {quo[lbg_pkg::DIV_NUM_W-2:0], fits};
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/lbg_back.sv
// Back end: averages, scales and smooths a group, then looks up the charge.
`default_nettype none

module lbg_back (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire lbg_pkg::lbg_cfg_t     cfg,
  input  wire logic                  q_empty,
  input  wire lbg_pkg::lbg_job_t     q_data,
  output      logic                  q_pop,
  output      lbg_pkg::lbg_div_req_t div_req,
  input  wire lbg_pkg::lbg_div_rsp_t div_rsp,
  output      logic                  out_valid,
  input  wire logic                  out_ready,
  output      lbg_pkg::lbg_out_t     out_item
);

  lbg_pkg::lbg_state_t state;
  lbg_pkg::lbg_state_t state_next;

  // Job and arithmetic registers.
  lbg_pkg::lbg_job_t                  job;
  logic [lbg_pkg::ADC_BITS-1:0]       avg;
  logic [lbg_pkg::DIV_NUM_W-1:0]      pin_prod;
  logic [lbg_pkg::ADC_BITS-1:0]       pin;
  logic [27:0]                        gain_prod;
  logic [43:0]                        trim_prod;
  logic [lbg_pkg::EMA_W-1:0]          smoothed_mv;
  logic [lbg_pkg::EMA_W-1:0]          ema_diff;
  logic                               ema_up;
  logic [47:0]                        ema_prod;
  logic [lbg_pkg::MV_W-1:0]           mv;
  logic [lbg_pkg::PCT_W-1:0]          pct;
  logic [lbg_pkg::CURVE_IDX_W-1:0]    idx;
  logic [lbg_pkg::MV_W-1:0]           seg_lm;
  logic [lbg_pkg::MV_W-1:0]           seg_dm;
  logic [lbg_pkg::PCT_W-1:0]          seg_lp;
  logic [lbg_pkg::PCT_W-1:0]          seg_dp;
  logic [lbg_pkg::DIV_NUM_W-1:0]      seg_num;

  // Combinational helpers.
  logic [lbg_pkg::ADC_BITS-1:0]       pin_est;
  logic [lbg_pkg::ADC_BITS:0]         pin_rem;
  logic [lbg_pkg::EMA_W-1:0]          reading;
  logic [lbg_pkg::EMA_W:0]            mv_round;
  logic [lbg_pkg::CURVE_IDX_W-1:0]    idx_prev;
  logic [lbg_pkg::MV_W-1:0]           cur_mv;
  logic [lbg_pkg::MV_W-1:0]           prev_mv;
  logic [lbg_pkg::PCT_W-1:0]          cur_pct;
  logic [lbg_pkg::PCT_W-1:0]          prev_pct;
  logic                               seg_hit;
  logic                               seg_bad;
  logic                               scan_last;
  logic [lbg_pkg::DIV_NUM_W:0]        soc_sum;
  logic                               seed_load;
  logic                               out_load;

  // Division by the full-scale code: the shifted estimate is at most one short,
  // and the remainder left by the estimate decides the correction.
  assign pin_est   = pin_prod[lbg_pkg::DIV_NUM_W-1:lbg_pkg::ADC_BITS];
  assign pin_rem   = {1'b0, pin_prod[lbg_pkg::ADC_BITS-1:0]} + {1'b0, pin_est};

  assign reading   = trim_prod[43:12];
  assign mv_round  = {1'b0, smoothed_mv} + lbg_pkg::ROUND_HALF;
  assign idx_prev  = idx - 1'b1;
  assign cur_mv    = lbg_pkg::CURVE_MV[idx];
  assign prev_mv   = lbg_pkg::CURVE_MV[idx_prev];
  assign cur_pct   = lbg_pkg::CURVE_PCT[idx];
  assign prev_pct  = lbg_pkg::CURVE_PCT[idx_prev];
  assign seg_hit   = mv >= cur_mv;
  assign seg_bad   = (prev_mv <= cur_mv) || (prev_pct < cur_pct);
  assign scan_last = idx == lbg_pkg::CURVE_IDX_W'(lbg_pkg::CURVE_POINTS - 1);
  assign soc_sum   = {1'b0, div_rsp.quotient} + (lbg_pkg::DIV_NUM_W+1)'(seg_lp);
  assign seed_load = job.seed || (smoothed_mv == '0);

  // Next-state logic of the sequencer.
  always_comb begin
    state_next = state;
    case (state)
      lbg_pkg::ST_IDLE: begin
        if (!q_empty) state_next = lbg_pkg::ST_AVG_GO;
      end
      lbg_pkg::ST_AVG_GO: begin
        state_next = (job.good == '0) ? lbg_pkg::ST_MUL_PIN : lbg_pkg::ST_AVG_WAIT;
      end
      lbg_pkg::ST_AVG_WAIT: begin
        if (div_rsp.done) state_next = lbg_pkg::ST_MUL_PIN;
      end
      lbg_pkg::ST_MUL_PIN:  state_next = lbg_pkg::ST_PIN_DIV;
      lbg_pkg::ST_PIN_DIV:  state_next = lbg_pkg::ST_MUL_GAIN;
      lbg_pkg::ST_MUL_GAIN: state_next = lbg_pkg::ST_MUL_TRIM;
      lbg_pkg::ST_MUL_TRIM: state_next = lbg_pkg::ST_EMA_DIFF;
      lbg_pkg::ST_EMA_DIFF: begin
        state_next = seed_load ? lbg_pkg::ST_ROUND : lbg_pkg::ST_EMA_MUL;
      end
      lbg_pkg::ST_EMA_MUL:  state_next = lbg_pkg::ST_EMA_UPD;
      lbg_pkg::ST_EMA_UPD:  state_next = lbg_pkg::ST_ROUND;
      lbg_pkg::ST_ROUND: begin
        state_next = lbg_pkg::ST_SCAN;
      end
      lbg_pkg::ST_SCAN: begin
        if (mv >= lbg_pkg::CURVE_MV[0] ||
            mv <= lbg_pkg::CURVE_MV[lbg_pkg::CURVE_POINTS-1]) begin
          state_next = lbg_pkg::ST_EMIT;
        end else if (seg_hit) begin
          state_next = seg_bad ? lbg_pkg::ST_EMIT : lbg_pkg::ST_SEG_MUL;
        end else if (scan_last) begin
          state_next = lbg_pkg::ST_EMIT;
        end
      end
      lbg_pkg::ST_SEG_MUL:  state_next = lbg_pkg::ST_SOC_GO;
      lbg_pkg::ST_SOC_GO:   state_next = lbg_pkg::ST_SOC_WAIT;
      lbg_pkg::ST_SOC_WAIT: begin
        if (div_rsp.done) state_next = lbg_pkg::ST_EMIT;
      end
      lbg_pkg::ST_EMIT: begin
        if (!out_valid || out_ready) state_next = lbg_pkg::ST_IDLE;
      end
      default: state_next = lbg_pkg::ST_IDLE;
    endcase
  end

  // Control outputs of the sequencer.
  always_comb begin
    q_pop            = 1'b0;
    out_load         = 1'b0;
    div_req.start    = 1'b0;
    div_req.dividend = '0;
    div_req.divisor  = '0;
    case (state)
      lbg_pkg::ST_IDLE: begin
        q_pop = !q_empty;
      end
      lbg_pkg::ST_AVG_GO: begin
        div_req.start    = job.good != '0;
        div_req.dividend = lbg_pkg::DIV_NUM_W'(job.sum);
        div_req.divisor  = lbg_pkg::DIV_DEN_W'(job.good);
      end
      lbg_pkg::ST_SOC_GO: begin
        div_req.start    = 1'b1;
        div_req.dividend = seg_num;
        div_req.divisor  = seg_dm;
      end
      lbg_pkg::ST_EMIT: begin
        out_load = !out_valid || out_ready;
      end
      default: begin
        q_pop = 1'b0;
      end
    endcase
  end

  // Sequencer state and the smoothed average, which persists across groups.
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= lbg_pkg::ST_IDLE;
      smoothed_mv <= '0;
    end else begin
      state <= state_next;
      if (state == lbg_pkg::ST_EMA_DIFF && seed_load) begin
        smoothed_mv <= reading;
      end else if (state == lbg_pkg::ST_EMA_UPD) begin
        smoothed_mv <= ema_up ? smoothed_mv + ema_prod[47:16]
                              : smoothed_mv - ema_prod[47:16];
      end
    end
  end

  // Arithmetic steps, one register stage per state.
  always_ff @(posedge clk) begin
    case (state)
      lbg_pkg::ST_IDLE: begin
        if (!q_empty) job <= q_data;
      end
      lbg_pkg::ST_AVG_GO: begin
        if (job.good == '0) avg <= '0;
      end
      lbg_pkg::ST_AVG_WAIT: begin
        if (div_rsp.done) avg <= div_rsp.quotient[lbg_pkg::ADC_BITS-1:0];
      end
      lbg_pkg::ST_MUL_PIN: begin
        pin_prod <= lbg_pkg::DIV_NUM_W'(avg) * lbg_pkg::DIV_NUM_W'(lbg_pkg::PIN_FULL_MV);
      end
      lbg_pkg::ST_PIN_DIV: begin
        pin <= (pin_rem >= {1'b0, lbg_pkg::ADC_FULL}) ? pin_est + 1'b1 : pin_est;
      end
      lbg_pkg::ST_MUL_GAIN: begin
        gain_prod <= 28'(pin) * 28'(cfg.divider_gain);
      end
      lbg_pkg::ST_MUL_TRIM: begin
        trim_prod <= 44'(gain_prod) * 44'(cfg.cal_trim);
      end
      lbg_pkg::ST_EMA_DIFF: begin
        ema_up   <= reading >= smoothed_mv;
        ema_diff <= (reading >= smoothed_mv) ? reading - smoothed_mv
                                             : smoothed_mv - reading;
      end
      lbg_pkg::ST_EMA_MUL: begin
        ema_prod <= 48'(ema_diff) * 48'(cfg.ema_alpha);
      end
      lbg_pkg::ST_ROUND: begin
        mv  <= mv_round[lbg_pkg::EMA_W] ? lbg_pkg::MV_MAX
                                        : mv_round[lbg_pkg::EMA_W-1:16];
        idx <= lbg_pkg::CURVE_IDX_W'(1);
        pct <= '0;
      end
      lbg_pkg::ST_SCAN: begin
        if (mv >= lbg_pkg::CURVE_MV[0]) begin
          pct <= lbg_pkg::PCT_FULL;
        end else if (mv <= lbg_pkg::CURVE_MV[lbg_pkg::CURVE_POINTS-1]) begin
          pct <= '0;
        end else if (seg_hit) begin
          pct    <= cur_pct;
          seg_lm <= cur_mv;
          seg_dm <= prev_mv - cur_mv;
          seg_lp <= cur_pct;
          seg_dp <= prev_pct - cur_pct;
        end else if (scan_last) begin
          pct <= '0;
        end else begin
          idx <= idx + 1'b1;
        end
      end
      lbg_pkg::ST_SEG_MUL: begin
        seg_num <= lbg_pkg::DIV_NUM_W'(mv - seg_lm) * lbg_pkg::DIV_NUM_W'(seg_dp);
      end
      lbg_pkg::ST_SOC_WAIT: begin
        if (div_rsp.done) begin
          pct <= (soc_sum > (lbg_pkg::DIV_NUM_W+1)'(lbg_pkg::PCT_FULL))
                 ? lbg_pkg::PCT_FULL : soc_sum[lbg_pkg::PCT_W-1:0];
        end
      end
      default: begin
        job <= job;
      end
    endcase
  end

  // Output register: holds a result until it is taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_item.battery_mv      <= mv;
      out_item.battery_percent <= pct;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/lipo_battery_gauge.sv
// Li-Po battery gauge top level: configuration registers, front, queue, back and divider.
//
// The gauge takes one raw converter sample per cycle and averages the valid ones over
// groups of oversample_count samples. Each finished group goes through a short queue
// to a sequential back end, which converts the average to millivolts, applies the
// divider gain and calibration trim, smooths it with an exponential moving average
// and reports the rounded battery voltage with a state of charge from a 21-point
// discharge curve. The front accepts one sample per cycle as long as the queue has
// room; the back end takes one group at a time. Its longest steps are the shared
// one-bit-per-cycle divider, used for the average and for the curve interpolation,
// and the one-point-per-cycle scan of the curve; a group with no valid sample skips
// the average division, and a reading that clamps at either end of the curve skips
// the interpolation. A finished result waits in the output register while the back
// end starts on the next group.
`default_nettype none

module lipo_battery_gauge #(
  parameter int QUEUE_DEPTH = 2
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            in_valid,
  output      logic                            in_ready,
  input  wire lbg_pkg::lbg_in_t                in_item,
  output      logic                            out_valid,
  input  wire logic                            out_ready,
  output      lbg_pkg::lbg_out_t               out_item,
  input  wire logic                            cfg_write,
  input  wire logic [lbg_pkg::REG_IDX_W-1:0]   cfg_index,
  input  wire logic [lbg_pkg::REG_W-1:0]       cfg_data
);

  lbg_pkg::lbg_cfg_t     cfg;
  lbg_pkg::lbg_job_t     push_data;
  lbg_pkg::lbg_job_t     pop_data;
  lbg_pkg::lbg_div_req_t div_req;
  lbg_pkg::lbg_div_rsp_t div_rsp;
  logic                  q_push;
  logic                  q_pop;
  logic                  q_full;
  logic                  q_empty;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.oversample_count <= lbg_pkg::OVERSAMPLE_RST;
      cfg.divider_gain     <= lbg_pkg::DIV_GAIN_RST;
      cfg.cal_trim         <= lbg_pkg::CAL_TRIM_RST;
      cfg.ema_alpha        <= lbg_pkg::EMA_ALPHA_RST;
    end else if (cfg_write) begin
      case (cfg_index)
        lbg_pkg::REG_OVERSAMPLE: cfg.oversample_count <= cfg_data[lbg_pkg::CNT_W-1:0];
        lbg_pkg::REG_DIV_GAIN:   cfg.divider_gain     <= cfg_data;
        lbg_pkg::REG_CAL_TRIM:   cfg.cal_trim         <= cfg_data;
        lbg_pkg::REG_EMA_ALPHA:  cfg.ema_alpha        <= cfg_data;
        default: cfg <= cfg;
      endcase
    end
  end

  // Sample accumulation.
  lbg_front u_front (
    .clk              (clk),
    .rst              (rst),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_item          (in_item),
    .oversample_count (cfg.oversample_count),
    .q_full           (q_full),
    .q_push           (q_push),
    .q_data           (push_data)
  );

  // Queue of finished groups.
  lbg_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (push_data),
    .pop       (q_pop),
    .pop_data  (pop_data),
    .full      (q_full),
    .empty     (q_empty)
  );

  // Group processing.
  lbg_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .q_empty   (q_empty),
    .q_data    (pop_data),
    .q_pop     (q_pop),
    .div_req   (div_req),
    .div_rsp   (div_rsp),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
  );

  // Shared divider.
  lbg_divider u_divider (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

endmodule

`default_nettype wire
